// ===== hw/rtl/dds_pkg.sv =====
// ----------------------------------------------------------------------------
// dds_pkg
// Shared types and constants for the deadlock detection safety check block.
// ----------------------------------------------------------------------------
package dds_pkg;

   localparam int NPROC_DEF = 8;
   localparam int NRES_DEF  = 4;

   localparam int ACTION_W  = 2;
   localparam int PIDX_W    = 3;
   localparam int RIDX_W    = 2;
   localparam int UNITS_W   = 16;
   localparam int WORK_W    = 20;
   localparam int MASK_W    = 8;
   localparam int COUNT_W   = 4;
   localparam int IDX_MAX_W = 4;

   localparam logic [WORK_W-1:0] WORK_MAX = {WORK_W{1'b1}};

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD_ENTRY = 2'd0,
      ACT_LOAD_FREE  = 2'd1,
      ACT_RUN        = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PICK,
      ST_CHECK,
      ST_RELEASE,
      ST_ADVANCE,
      ST_REPORT
   } state_type;

   // control from the sequencer to the work vector datapath
   typedef struct packed {
      logic                 copy;
      logic                 free_we;
      logic [IDX_MAX_W-1:0] free_idx;
      logic [UNITS_W-1:0]   free_data;
      logic                 rel;
      logic [IDX_MAX_W-1:0] idx;
   } work_cmd_type;

endpackage

// ===== hw/rtl/dds_ram.sv =====
// ----------------------------------------------------------------------------
// dds_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/dds_work.sv =====
// ----------------------------------------------------------------------------
// dds_work
// Free-units and work vectors with the need compare and saturating release.
// ----------------------------------------------------------------------------
module dds_work #(
   parameter int NRES = dds_pkg::NRES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dds_pkg::work_cmd_type       cmd,
   input  logic [dds_pkg::UNITS_W-1:0] held,
   input  logic [dds_pkg::UNITS_W-1:0] need,
   output logic                        fit
);

   localparam int RW = (NRES > 1) ? $clog2(NRES) : 1;

   logic [dds_pkg::UNITS_W-1:0] free_ff [NRES];
   logic [dds_pkg::WORK_W-1:0]  work_ff [NRES];
   logic [dds_pkg::WORK_W-1:0]  work_sel;
   logic [dds_pkg::WORK_W:0]    sum;
   logic [dds_pkg::WORK_W-1:0]  sum_sat;
   logic [RW-1:0]               idx;
   logic [RW-1:0]               free_idx;

   assign idx      = cmd.idx[RW-1:0];
   assign free_idx = cmd.free_idx[RW-1:0];
   assign work_sel = work_ff[idx];
   assign fit      = (dds_pkg::WORK_W'(need) <= work_sel);
   assign sum      = (dds_pkg::WORK_W+1)'(work_sel) + (dds_pkg::WORK_W+1)'(held);
   assign sum_sat  = sum[dds_pkg::WORK_W] ? dds_pkg::WORK_MAX : sum[dds_pkg::WORK_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.free_we) begin
         free_ff[free_idx] <= cmd.free_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NRES; i++) begin
            work_ff[i] <= '0;
         end
      end else if (cmd.copy) begin
         for (int i = 0; i < NRES; i++) begin
            work_ff[i] <= dds_pkg::WORK_W'(free_ff[i]);
         end
      end else if (cmd.rel) begin
         work_ff[idx] <= sum_sat;
      end
   end

endmodule

// ===== hw/rtl/deadlock_detection_safety_check.sv =====
// ----------------------------------------------------------------------------
// deadlock_detection_safety_check
// Banker's safety check over a held/need table kept in one RAM.
// ----------------------------------------------------------------------------
// req channel: one beat per action. action 0 writes held units and the need
// (max minus held, clamped at zero) of one process/resource entry, action 1
// writes the free units of one resource, action 2 runs the check. loads give
// no rsp beat; action 3 and out-of-range loads are dropped.
// a run copies the free vector into the work vector and walks the processes
// in passes. each unfinished process compares its need row, read one entry
// at a time through the single read port of the table RAM, and, when it
// fits, reads its held row back the same way to add it to the work vector;
// a finished process only passes through the pick and advance steps.
// rsp carries deadlocked, the blocked mask and the finished count. it sits
// in an output register: req stays open for loads while it waits, and a
// further run holds in its report step until the rsp register is free.
// reset clears the sequencer and the rsp register; table contents are not
// cleared and must be loaded before a run.
// ----------------------------------------------------------------------------
module deadlock_detection_safety_check #(
   parameter int NPROC = dds_pkg::NPROC_DEF,
   parameter int NRES  = dds_pkg::NRES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [dds_pkg::ACTION_W-1:0] req_action,
   input  logic [dds_pkg::PIDX_W-1:0]   req_process_index,
   input  logic [dds_pkg::RIDX_W-1:0]   req_resource_index,
   input  logic [dds_pkg::UNITS_W-1:0]  req_held_units,
   input  logic [dds_pkg::UNITS_W-1:0]  req_max_units,
   input  logic [dds_pkg::UNITS_W-1:0]  req_free_units,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_deadlocked,
   output logic [dds_pkg::MASK_W-1:0]   rsp_blocked_mask,
   output logic [dds_pkg::COUNT_W-1:0]  rsp_finished_count
);

   localparam int PW    = (NPROC > 1) ? $clog2(NPROC) : 1;
   localparam int RW    = (NRES > 1) ? $clog2(NRES) : 1;
   localparam int CW    = $clog2(NRES + 1);
   localparam int NW    = $clog2(NPROC + 1);
   localparam int AW    = PW + RW;
   localparam int DEPTH = 1 << AW;
   localparam int DW    = 2 * dds_pkg::UNITS_W;

   dds_pkg::state_type state_ff, state_in;

   logic [PW-1:0]    proc_ff, proc_in;
   logic [PW-1:0]    pass_ff, pass_in;
   logic [CW-1:0]    iss_ff, iss_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [RW-1:0]    rd_idx_ff, rd_idx_in;
   logic             fit_ff, fit_in;
   logic             progress_ff, progress_in;
   logic [NW-1:0]    done_ff, done_in;
   logic [NPROC-1:0] flags_ff, flags_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_dead_ff, rsp_dead_in;
   logic [dds_pkg::MASK_W-1:0]  rsp_mask_ff, rsp_mask_in;
   logic [dds_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [dds_pkg::MASK_W-1:0]  blocked;

   logic                        req_fire;
   logic                        issuing;
   logic                        rd_last;
   logic                        report_fire;
   logic                        entry_ok;
   logic                        free_ok;
   logic [dds_pkg::UNITS_W-1:0] load_need;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [DW-1:0] ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic [DW-1:0] ram_rdata;

   dds_pkg::work_cmd_type cmd;
   logic                  chk_fit;

   assign req_ready   = (state_ff == dds_pkg::ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign issuing     = (iss_ff != CW'(NRES));
   assign rd_last     = (rd_idx_ff == RW'(NRES - 1));
   assign report_fire = !rsp_valid_ff || rsp_ready;
   assign entry_ok    = (32'(req_process_index) < NPROC) && (32'(req_resource_index) < NRES);
   assign free_ok     = (32'(req_resource_index) < NRES);
   assign load_need   = (req_max_units > req_held_units) ? (req_max_units - req_held_units)
                                                          : '0;

   for (genvar g = 0; g < dds_pkg::MASK_W; g++) begin : g_mask
      if (g < NPROC) begin : g_live
         assign blocked[g] = !flags_ff[g];
      end else begin : g_none
         assign blocked[g] = 1'b0;
      end
   end

   dds_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   dds_work #(
      .NRES (NRES)
   ) u_work (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .held  (ram_rdata[DW-1:dds_pkg::UNITS_W]),
      .need  (ram_rdata[dds_pkg::UNITS_W-1:0]),
      .fit   (chk_fit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dds_pkg::ST_IDLE: begin
            if (req_fire && (req_action == dds_pkg::ACT_RUN)) begin
               state_in = dds_pkg::ST_PICK;
            end
         end
         dds_pkg::ST_PICK: begin
            state_in = flags_ff[proc_ff] ? dds_pkg::ST_ADVANCE : dds_pkg::ST_CHECK;
         end
         dds_pkg::ST_CHECK: begin
            if (rd_vld_ff && rd_last) begin
               state_in = (fit_ff && chk_fit) ? dds_pkg::ST_RELEASE : dds_pkg::ST_ADVANCE;
            end
         end
         dds_pkg::ST_RELEASE: begin
            if (rd_vld_ff && rd_last) begin
               state_in = dds_pkg::ST_ADVANCE;
            end
         end
         dds_pkg::ST_ADVANCE: begin
            if (proc_ff != PW'(NPROC - 1)) begin
               state_in = dds_pkg::ST_PICK;
            end else if (progress_ff && (pass_ff != PW'(NPROC - 1))) begin
               state_in = dds_pkg::ST_PICK;
            end else begin
               state_in = dds_pkg::ST_REPORT;
            end
         end
         dds_pkg::ST_REPORT: begin
            if (report_fire) begin
               state_in = dds_pkg::ST_IDLE;
            end
         end
         default: state_in = dds_pkg::ST_IDLE;
      endcase
   end

   // datapath control and counters
   always_comb begin
      proc_in     = proc_ff;
      pass_in     = pass_ff;
      iss_in      = iss_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = iss_ff[RW-1:0];
      fit_in      = fit_ff;
      progress_in = progress_ff;
      done_in     = done_ff;
      flags_in    = flags_ff;

      ram_we    = 1'b0;
      ram_waddr = {PW'(req_process_index), RW'(req_resource_index)};
      ram_wdata = {req_held_units, load_need};
      ram_re    = 1'b0;
      ram_raddr = {proc_ff, iss_ff[RW-1:0]};

      cmd           = '0;
      cmd.free_idx  = dds_pkg::IDX_MAX_W'(req_resource_index);
      cmd.free_data = req_free_units;
      cmd.idx       = dds_pkg::IDX_MAX_W'(rd_idx_ff);

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dead_in  = rsp_dead_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff)
         dds_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_action)
                  dds_pkg::ACT_LOAD_ENTRY: ram_we = entry_ok;
                  dds_pkg::ACT_LOAD_FREE:  cmd.free_we = free_ok;
                  dds_pkg::ACT_RUN: begin
                     cmd.copy    = 1'b1;
                     flags_in    = '0;
                     done_in     = '0;
                     proc_in     = '0;
                     pass_in     = '0;
                     progress_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         dds_pkg::ST_PICK: begin
            iss_in = '0;
            fit_in = 1'b1;
         end
         dds_pkg::ST_CHECK: begin
            if (issuing) begin
               ram_re    = 1'b1;
               rd_vld_in = 1'b1;
               iss_in    = iss_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               fit_in = fit_ff && chk_fit;
               if (rd_last) begin
                  iss_in = '0;
               end
            end
         end
         dds_pkg::ST_RELEASE: begin
            if (issuing) begin
               ram_re    = 1'b1;
               rd_vld_in = 1'b1;
               iss_in    = iss_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               cmd.rel = 1'b1;
               if (rd_last) begin
                  flags_in[proc_ff] = 1'b1;
                  done_in           = done_ff + NW'(1);
                  progress_in       = 1'b1;
               end
            end
         end
         dds_pkg::ST_ADVANCE: begin
            if (proc_ff != PW'(NPROC - 1)) begin
               proc_in = proc_ff + PW'(1);
            end else if (progress_ff && (pass_ff != PW'(NPROC - 1))) begin
               proc_in     = '0;
               pass_in     = pass_ff + PW'(1);
               progress_in = 1'b0;
            end
         end
         dds_pkg::ST_REPORT: begin
            if (report_fire) begin
               rsp_valid_in = 1'b1;
               rsp_dead_in  = (done_ff != NW'(NPROC));
               rsp_mask_in  = blocked;
               rsp_count_in = dds_pkg::COUNT_W'(done_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dds_pkg::ST_IDLE;
         proc_ff      <= '0;
         pass_ff      <= '0;
         iss_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         fit_ff       <= 1'b0;
         progress_ff  <= 1'b0;
         done_ff      <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         proc_ff      <= proc_in;
         pass_ff      <= pass_in;
         iss_ff       <= iss_in;
         rd_vld_ff    <= rd_vld_in;
         fit_ff       <= fit_in;
         progress_ff  <= progress_in;
         done_ff      <= done_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      rsp_dead_ff  <= rsp_dead_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_deadlocked     = rsp_dead_ff;
   assign rsp_blocked_mask   = rsp_mask_ff;
   assign rsp_finished_count = rsp_count_ff;

endmodule

// ===== hw/rtl/dds_check.sv =====
// ----------------------------------------------------------------------------
// dds_check
// Port-level checks for the deadlock detection safety check block.
// ----------------------------------------------------------------------------
module dds_check #(
   parameter int NPROC = dds_pkg::NPROC_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [dds_pkg::ACTION_W-1:0] req_action,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_deadlocked,
   input logic [dds_pkg::MASK_W-1:0]   rsp_blocked_mask,
   input logic [dds_pkg::COUNT_W-1:0]  rsp_finished_count
);

   // a stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_deadlocked)
         && $stable(rsp_blocked_mask) && $stable(rsp_finished_count))
      else $error("rsp beat changed while stalled");

   // a run closes the req side while the tables are walked
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == dds_pkg::ACT_RUN) |=> !req_ready)
      else $error("req accepted during a run");

   // no deadlock means nothing is blocked
   a_clear_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_deadlocked |-> (rsp_blocked_mask == '0))
      else $error("blocked processes reported without deadlock");

   // no deadlock means every process finished
   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_deadlocked |-> (rsp_finished_count == dds_pkg::COUNT_W'(NPROC)))
      else $error("finished count short without deadlock");

endmodule

bind deadlock_detection_safety_check dds_check #(
   .NPROC (NPROC)
) u_dds_check (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_action         (req_action),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_deadlocked     (rsp_deadlocked),
   .rsp_blocked_mask   (rsp_blocked_mask),
   .rsp_finished_count (rsp_finished_count)
);

// ===== test/tb_deadlock_detection_safety_check.sv =====
// ----------------------------------------------------------------------------
// tb_deadlock_detection_safety_check
// Self-checking bench for the banker's safety check. It loads the held/need tables
// and the free vector over req, runs checks, and compares every rsp beat with a
// typed verdict or a local model of the safety walk. A directed table comes first,
// then random load/run scenarios, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_deadlock_detection_safety_check;

   localparam int NPROC        = dds_pkg::NPROC_DEF;
   localparam int NRES         = dds_pkg::NRES_DEF;
   localparam int ACTION_W     = dds_pkg::ACTION_W;
   localparam int PIDX_W       = dds_pkg::PIDX_W;
   localparam int RIDX_W       = dds_pkg::RIDX_W;
   localparam int UNITS_W      = dds_pkg::UNITS_W;
   localparam int WORK_W       = dds_pkg::WORK_W;
   localparam int MASK_W       = dds_pkg::MASK_W;
   localparam int COUNT_W      = dds_pkg::COUNT_W;
   localparam logic [WORK_W-1:0] WORK_MAX = dds_pkg::WORK_MAX;
   localparam int RANDOM_BEATS = 795;
   localparam int SCRIPT_ROWS  = 19;
   localparam int DRAIN_CYCLES = 800;
   localparam int LIMIT_CYCLES = 4000000;

   // action code the block drops
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [PIDX_W-1:0]   pidx;
      logic [RIDX_W-1:0]   ridx;
      logic [UNITS_W-1:0]  held;
      logic [UNITS_W-1:0]  maxu;
      logic [UNITS_W-1:0]  freeu;
   } req_beat_type;

   typedef struct packed {
      logic               deadlocked;
      logic [MASK_W-1:0]  blocked;
      logic [COUNT_W-1:0] finished;
   } verdict_type;

   typedef struct packed {
      req_beat_type beat;
      logic         typed;
      verdict_type  want;
   } script_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [ACTION_W-1:0] req_action = '0;
   logic [PIDX_W-1:0]   req_process_index = '0;
   logic [RIDX_W-1:0]   req_resource_index = '0;
   logic [UNITS_W-1:0]  req_held_units = '0;
   logic [UNITS_W-1:0]  req_max_units = '0;
   logic [UNITS_W-1:0]  req_free_units = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_deadlocked;
   logic [MASK_W-1:0]   rsp_blocked_mask;
   logic [COUNT_W-1:0]  rsp_finished_count;

   // local copy of the tables
   logic [UNITS_W-1:0] alloc_tab [NPROC][NRES];
   logic [UNITS_W-1:0] claim_tab [NPROC][NRES];
   logic [UNITS_W-1:0] pool_vec [NRES];

   verdict_type verdicts_due [$];
   int          errors = 0;
   logic        quiet = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   deadlock_detection_safety_check i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_process_index  (req_process_index),
      .req_resource_index (req_resource_index),
      .req_held_units     (req_held_units),
      .req_max_units      (req_max_units),
      .req_free_units     (req_free_units),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_deadlocked     (rsp_deadlocked),
      .rsp_blocked_mask   (rsp_blocked_mask),
      .rsp_finished_count (rsp_finished_count)
   );

   // banker's walk over the local tables
   function automatic verdict_type assess_safety();
      logic [WORK_W-1:0] avail [NRES];
      logic [WORK_W:0]   sum;
      logic [NPROC-1:0]  done_flags;
      logic              progress;
      logic              fits;
      int                cnt;
      verdict_type       v;
      for (int r = 0; r < NRES; r++) begin
         avail[r] = {{(WORK_W-UNITS_W){1'b0}}, pool_vec[r]};
      end
      done_flags = '0;
      for (int pass = 0; pass < NPROC; pass++) begin
         progress = 1'b0;
         for (int p = 0; p < NPROC; p++) begin
            if (!done_flags[p]) begin
               fits = 1'b1;
               for (int r = 0; r < NRES; r++) begin
                  if ({{(WORK_W-UNITS_W){1'b0}}, claim_tab[p][r]} > avail[r]) begin
                     fits = 1'b0;
                  end
               end
               if (fits) begin
                  // freed units go back at once, later processes see them
                  for (int r = 0; r < NRES; r++) begin
                     sum = {1'b0, avail[r]}
                         + {{(WORK_W-UNITS_W+1){1'b0}}, alloc_tab[p][r]};
                     avail[r] = (sum > {1'b0, WORK_MAX}) ? WORK_MAX : sum[WORK_W-1:0];
                  end
                  done_flags[p] = 1'b1;
                  progress = 1'b1;
               end
            end
         end
         if (!progress) break;
      end
      cnt = 0;
      for (int p = 0; p < NPROC; p++) begin
         if (done_flags[p]) cnt++;
      end
      v.deadlocked = (cnt < NPROC);
      v.blocked    = ~done_flags[MASK_W-1:0];
      v.finished   = COUNT_W'(cnt);
      return v;
   endfunction

   // directed table; a typed verdict is used as it stands, the rest are predicted
   function automatic script_type script_row(input int i);
      script_type s;
      case (i)
         // every process needs one unit of each resource, nothing free: all blocked
         0:  s = {dds_pkg::ACT_RUN,        3'd0, 2'd0, 16'h0000, 16'h0000, 16'h0000,
                  1'b1, 1'b1, 8'hFF, 4'd0};
         1:  s = {dds_pkg::ACT_LOAD_FREE,  3'd7, 2'd0, 16'hFFFF, 16'hFFFF, 16'h0001,
                  1'b0, 1'b0, 8'h00, 4'd0};
         2:  s = {dds_pkg::ACT_LOAD_FREE,  3'd0, 2'd1, 16'h0000, 16'h0000, 16'h0001,
                  1'b0, 1'b0, 8'h00, 4'd0};
         3:  s = {dds_pkg::ACT_LOAD_FREE,  3'd7, 2'd2, 16'hFFFF, 16'hFFFF, 16'h0001,
                  1'b0, 1'b0, 8'h00, 4'd0};
         4:  s = {dds_pkg::ACT_LOAD_FREE,  3'd0, 2'd3, 16'h0000, 16'h0000, 16'h0001,
                  1'b0, 1'b0, 8'h00, 4'd0};
         // all finish in the first pass, the second finishes nothing
         5:  s = {dds_pkg::ACT_RUN,        3'd0, 2'd0, 16'h0000, 16'h0000, 16'h0000,
                  1'b1, 1'b0, 8'h00, 4'd8};
         6:  s = {dds_pkg::ACT_LOAD_ENTRY, 3'd3, 2'd0, 16'h0000, 16'hFFFF, 16'hFFFF,
                  1'b0, 1'b0, 8'h00, 4'd0};
         7:  s = {dds_pkg::ACT_RUN,        3'd0, 2'd0, 16'h0000, 16'h0000, 16'h0000,
                  1'b1, 1'b1, 8'h08, 4'd7};
         8:  s = {dds_pkg::ACT_LOAD_FREE,  3'd7, 2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  1'b0, 1'b0, 8'h00, 4'd0};
         9:  s = {dds_pkg::ACT_RUN,        3'd0, 2'd0, 16'h0000, 16'h0000, 16'h0000,
                  1'b1, 1'b0, 8'h00, 4'd8};
         // held above max: need clamps at zero
         10: s = {dds_pkg::ACT_LOAD_ENTRY, 3'd5, 2'd2, 16'hFFFF, 16'h0000, 16'hFFFF,
                  1'b0, 1'b0, 8'h00, 4'd0};
         11: s = {dds_pkg::ACT_LOAD_ENTRY, 3'd0, 2'd2, 16'h0000, 16'hFFFF, 16'h0000,
                  1'b0, 1'b0, 8'h00, 4'd0};
         // process 0 only fits on the second pass
         12: s = {dds_pkg::ACT_RUN,        3'd0, 2'd0, 16'h0000, 16'h0000, 16'h0000,
                  1'b0, 1'b0, 8'h00, 4'd0};
         13: s = {ACT_SPARE,               3'd7, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  1'b0, 1'b0, 8'h00, 4'd0};
         14: s = {dds_pkg::ACT_RUN,        3'd0, 2'd0, 16'h0000, 16'h0000, 16'h0000,
                  1'b0, 1'b0, 8'h00, 4'd0};
         15: s = {dds_pkg::ACT_LOAD_ENTRY, 3'd1, 2'd3, 16'h0005, 16'h0009, 16'h0000,
                  1'b0, 1'b0, 8'h00, 4'd0};
         16: s = {dds_pkg::ACT_LOAD_ENTRY, 3'd2, 2'd3, 16'h0005, 16'h0009, 16'h0000,
                  1'b0, 1'b0, 8'h00, 4'd0};
         17: s = {dds_pkg::ACT_LOAD_FREE,  3'd0, 2'd3, 16'h0000, 16'h0000, 16'h0003,
                  1'b0, 1'b0, 8'h00, 4'd0};
         default:
             s = {dds_pkg::ACT_RUN,        3'd0, 2'd0, 16'h0000, 16'h0000, 16'h0000,
                  1'b0, 1'b0, 8'h00, 4'd0};
      endcase
      return s;
   endfunction

   function automatic logic [UNITS_W-1:0] units_for(input int mode);
      logic [UNITS_W-1:0] u;
      case (mode)
         0:       u = UNITS_W'($urandom_range(0, 3));
         1:       u = UNITS_W'($urandom_range(0, 12));
         2: begin
            case ($urandom_range(0, 3))
               0:       u = '0;
               1:       u = 16'h0001;
               2:       u = 16'hFFFE;
               default: u = '1;
            endcase
         end
         default: u = UNITS_W'($urandom);
      endcase
      return u;
   endfunction

   // drive one beat, wait for it to be taken, then update the local tables
   task automatic send_beat(input req_beat_type b, input logic typed, input verdict_type want);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_action         = b.action;
      req_process_index  = b.pidx;
      req_resource_index = b.ridx;
      req_held_units     = b.held;
      req_max_units      = b.maxu;
      req_free_units     = b.freeu;
      req_valid          = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (b.action == dds_pkg::ACT_LOAD_ENTRY) begin
         alloc_tab[b.pidx][b.ridx] = b.held;
         claim_tab[b.pidx][b.ridx] = (b.maxu > b.held) ? b.maxu - b.held : '0;
      end else if (b.action == dds_pkg::ACT_LOAD_FREE) begin
         pool_vec[b.ridx] = b.freeu;
      end else if (b.action == dds_pkg::ACT_RUN) begin
         verdicts_due.push_back(typed ? want : assess_safety());
      end
      @(negedge clock);
   endtask

   initial begin : rsp_side
      int stall;
      while (reset) @(negedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdicts_due.size() == 0) begin
            $display("%0t: rsp beat expected none actual dl=%0b mask=%h count=%0d",
                     $time, rsp_deadlocked, rsp_blocked_mask, rsp_finished_count);
            errors++;
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_deadlocked !== want.deadlocked) begin
               $display("%0t: deadlocked expected %0b actual %0b",
                        $time, want.deadlocked, rsp_deadlocked);
               errors++;
            end
            if (rsp_blocked_mask !== want.blocked) begin
               $display("%0t: blocked_mask expected %h actual %h",
                        $time, want.blocked, rsp_blocked_mask);
               errors++;
            end
            if (rsp_finished_count !== want.finished) begin
               $display("%0t: finished_count expected %0d actual %0d",
                        $time, want.finished, rsp_finished_count);
               errors++;
            end
         end
      end
   end

   initial begin : watchdog
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("deadlock_detection_safety_check regression: fail");
      $finish;
   end

   initial begin : stimulus
      req_beat_type b;
      script_type   s;
      verdict_type  none;
      int           beats;
      int           mode;
      int           nload;
      none = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // every entry written before any run: need one of everything, nothing free
      for (int k = 0; k < NPROC * NRES; k++) begin
         b = {dds_pkg::ACT_LOAD_ENTRY, PIDX_W'(k / NRES), RIDX_W'(k % NRES),
              16'h0000, 16'h0001, 16'h0000};
         send_beat(b, 1'b0, none);
      end
      for (int r = 0; r < NRES; r++) begin
         b = {dds_pkg::ACT_LOAD_FREE, 3'd0, RIDX_W'(r), 16'h0000, 16'h0000, 16'h0000};
         send_beat(b, 1'b0, none);
      end

      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         s = script_row(i);
         send_beat(s.beat, s.typed, s.want);
      end

      // random scenarios: a batch of loads then a run
      beats = 0;
      while (beats < RANDOM_BEATS) begin
         quiet = ($urandom_range(0, 5) == 0);
         mode  = $urandom_range(0, 3);
         nload = ($urandom_range(0, 9) == 0) ? NPROC * NRES + NRES : $urandom_range(1, 12);
         for (int k = 0; k < nload; k++) begin
            if ($urandom_range(0, 11) == 0) begin
               b = {ACT_SPARE, PIDX_W'($urandom), RIDX_W'($urandom),
                    UNITS_W'($urandom), UNITS_W'($urandom), UNITS_W'($urandom)};
               send_beat(b, 1'b0, none);
               beats++;
            end
            b.held  = units_for(mode);
            b.maxu  = units_for(mode);
            b.freeu = units_for(mode);
            if (nload > 12) begin
               // full rewrite walks the table in order, then the free vector
               b.action = (k < NPROC * NRES) ? dds_pkg::ACT_LOAD_ENTRY
                                             : dds_pkg::ACT_LOAD_FREE;
               b.pidx   = (k < NPROC * NRES) ? PIDX_W'(k / NRES) : PIDX_W'($urandom);
               b.ridx   = RIDX_W'(k % NRES);
            end else begin
               b.action = ($urandom_range(0, 3) == 0) ? dds_pkg::ACT_LOAD_FREE
                                                      : dds_pkg::ACT_LOAD_ENTRY;
               b.pidx   = PIDX_W'($urandom);
               b.ridx   = RIDX_W'($urandom);
            end
            send_beat(b, 1'b0, none);
            beats++;
         end
         b = {dds_pkg::ACT_RUN, PIDX_W'($urandom), RIDX_W'($urandom),
              UNITS_W'($urandom), UNITS_W'($urandom), UNITS_W'($urandom)};
         send_beat(b, 1'b0, none);
         beats++;
         if ($urandom_range(0, 7) == 0) begin
            send_beat(b, 1'b0, none);
            beats++;
         end
      end
      req_valid = 1'b0;
      quiet = 1'b0;

      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("deadlock_detection_safety_check regression: pass");
      end else begin
         $display("deadlock_detection_safety_check regression: fail");
      end
      $finish;
   end

endmodule
